FILE: design/ase_pkg.sv
`default_nettype none

package ase_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int INDEX_W   = 7;
  localparam int STEP_W    = 15;
  localparam int CODE_W    = 4;
  localparam int NUM_W     = 21;
  localparam int REM_W     = NUM_W - 1;
  localparam int SHIFT_W   = 3;
  localparam int DIV_STEPS = 5;

  localparam logic [INDEX_W-1:0] INDEX_MAX = 7'd88;
  localparam logic [CODE_W-1:0]  CODE_MAX  = 4'd15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_UPD,
    ST_DONE
  } ase_state_t;

  // one command per cycle to the shared compare-subtract unit
  typedef struct packed {
    logic               load;
    logic               iter;
    logic [SHIFT_W-1:0] shift;
  } div_cmd_t;

  function automatic logic [STEP_W-1:0] step_of(input logic [INDEX_W-1:0] idx);
    logic [STEP_W-1:0] s;
    unique case (idx)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
      7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
      7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
      7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
      7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
      7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
      7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
      7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
      7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
      7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
      7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
      7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
      7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
      7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
      7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
      7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
      7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
      7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
      7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
      7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
      7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
      7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
      7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  function automatic logic signed [4:0] index_adjust(input logic [CODE_W-1:0] code);
    logic signed [4:0] a;
    unique case (code)
      4'd0, 4'd15: a = 5'sd8;
      4'd1, 4'd14: a = 5'sd6;
      4'd2, 4'd13: a = 5'sd4;
      4'd3, 4'd12: a = 5'sd2;
      default:     a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: design/ase_in_if.sv
`default_nettype none

interface ase_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               last_pair;

  modport source(output valid, output left_sample, output right_sample,
                 output last_pair, input ready);
  modport sink(input valid, input left_sample, input right_sample,
               input last_pair, output ready);
endinterface

`default_nettype wire

FILE: design/ase_out_if.sv
`default_nettype none

interface ase_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_code;

  modport source(output valid, output code_byte, output last_code, input ready);
  modport sink(input valid, input code_byte, input last_code, output ready);
endinterface

`default_nettype wire

FILE: design/ase_divider.sv
`default_nettype none

module ase_divider (
  input  wire logic                         clk,
  input  wire ase_pkg::div_cmd_t            cmd,
  input  wire logic signed [ase_pkg::NUM_W-1:0]  num,
  input  wire logic [ase_pkg::STEP_W-1:0]   step,
  output logic [ase_pkg::CODE_W-1:0]        code
);
  import ase_pkg::*;

  logic [REM_W-1:0]  rem_r;
  logic [CODE_W-1:0] q_r;
  logic              neg_r;
  logic              sat_r;

  logic [REM_W-1:0]  divisor;
  logic [REM_W:0]    trial;

  assign divisor = REM_W'(step) << cmd.shift;
  assign trial   = {1'b0, rem_r} - {1'b0, divisor};

  // shift 4 only detects a quotient above 15, lower shifts build the code
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= num[REM_W-1:0];
      neg_r <= num[NUM_W-1];
      q_r   <= '0;
      sat_r <= 1'b0;
    end else if (cmd.iter && !trial[REM_W]) begin
      rem_r <= trial[REM_W-1:0];
      if (cmd.shift == SHIFT_W'(CODE_W)) begin
        sat_r <= 1'b1;
      end else begin
        q_r[cmd.shift[1:0]] <= 1'b1;
      end
    end
  end

  assign code = neg_r ? '0 : (sat_r ? CODE_MAX : q_r);

endmodule

`default_nettype wire

FILE: design/adpcm_stereo_encoder.sv
// each item is encoded left channel first, then right; each channel takes one
//   load step, five compare-subtract steps on the shared divider and one update
//   step; the code byte is registered once the output register is free
// the input is not ready while an item is in work
// reset (rst_n low, synchronous) clears predictors, step indexes and output valid
`default_nettype none

module adpcm_stereo_encoder (
  input  wire logic clk,
  input  wire logic rst_n,
  ase_in_if.sink    in_ch,
  ase_out_if.source out_ch
);
  import ase_pkg::*;

  ase_state_t state_r, state_nxt;
  logic       ch_r, ch_nxt;
  logic [SHIFT_W-1:0] cnt_r, cnt_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;

  logic signed [SAMPLE_W-1:0] lsmp_r, lsmp_nxt, rsmp_r, rsmp_nxt;
  logic                       last_r, last_nxt;
  logic signed [SAMPLE_W-1:0] lpred_r, lpred_nxt, rpred_r, rpred_nxt;
  logic [INDEX_W-1:0]         lidx_r, lidx_nxt, ridx_r, ridx_nxt;
  logic [CODE_W-1:0]          lcode_r, lcode_nxt, rcode_r, rcode_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  div_cmd_t div_cmd;
  logic [CODE_W-1:0] code;

  logic signed [SAMPLE_W-1:0] cur_sample, cur_pred;
  logic [INDEX_W-1:0]         cur_idx;
  logic [STEP_W-1:0]          cur_step;
  logic [SAMPLE_W:0]          diff;
  logic signed [NUM_W-1:0]    num;

  logic [18:0]        prod;
  logic [18:0]        step15;
  logic signed [19:0] psum;
  logic signed [SAMPLE_W-1:0] pred_new;
  logic signed [4:0]  adj;
  logic signed [7:0]  ni;
  logic [INDEX_W-1:0] idx_new;

  assign cur_sample = ch_r ? rsmp_r : lsmp_r;
  assign cur_pred   = ch_r ? rpred_r : lpred_r;
  assign cur_idx    = ch_r ? ridx_r : lidx_r;
  assign cur_step   = step_of(cur_idx);

  // numerator 4*(sample - pred) + 8*step
  assign diff = {cur_sample[SAMPLE_W-1], cur_sample} - {cur_pred[SAMPLE_W-1], cur_pred};
  assign num  = {{2{diff[SAMPLE_W]}}, diff, 2'b00} + {3'b000, cur_step, 3'b000};

  ase_divider u_divider (
    .clk  (clk),
    .cmd  (div_cmd),
    .num  (num),
    .step (step_r),
    .code (code)
  );

  // predictor and index update from the finished code
  always_comb begin
    prod   = {15'd0, code} * {4'd0, step_r};
    step15 = {step_r, 4'd0} - {4'd0, step_r};
    psum   = {{4{cur_pred[SAMPLE_W-1]}}, cur_pred} + {3'd0, prod[18:2]}
           - {4'd0, step15[18:3]};
    if (psum > 20'sd32767) begin
      pred_new = 16'sh7fff;
    end else if (psum < -20'sd32768) begin
      pred_new = 16'sh8000;
    end else begin
      pred_new = psum[SAMPLE_W-1:0];
    end
    adj = index_adjust(code);
    ni  = {1'b0, cur_idx} + {{3{adj[4]}}, adj};
    if (ni[7]) begin
      idx_new = '0;
    end else if (ni[INDEX_W-1:0] > INDEX_MAX) begin
      idx_new = INDEX_MAX;
    end else begin
      idx_new = ni[INDEX_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    lsmp_nxt      = lsmp_r;
    rsmp_nxt      = rsmp_r;
    last_nxt      = last_r;
    lpred_nxt     = lpred_r;
    rpred_nxt     = rpred_r;
    lidx_nxt      = lidx_r;
    ridx_nxt      = ridx_r;
    lcode_nxt     = lcode_r;
    rcode_nxt     = rcode_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    div_cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          lsmp_nxt  = in_ch.left_sample;
          rsmp_nxt  = in_ch.right_sample;
          last_nxt  = in_ch.last_pair;
          ch_nxt    = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        div_cmd.load = 1'b1;
        step_nxt     = cur_step;
        cnt_nxt      = SHIFT_W'(DIV_STEPS - 1);
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        div_cmd.iter  = 1'b1;
        div_cmd.shift = cnt_r;
        if (cnt_r == '0) begin
          state_nxt = ST_UPD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_UPD: begin
        if (!ch_r) begin
          lpred_nxt = pred_new;
          lidx_nxt  = idx_new;
          lcode_nxt = code;
          ch_nxt    = 1'b1;
          state_nxt = ST_LOAD;
        end else begin
          rpred_nxt = pred_new;
          ridx_nxt  = idx_new;
          rcode_nxt = code;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the finished item until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = {lcode_r, rcode_r};
          out_last_nxt  = last_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lpred_r     <= '0;
      rpred_r     <= '0;
      lidx_r      <= '0;
      ridx_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lpred_r     <= lpred_nxt;
      rpred_r     <= rpred_nxt;
      lidx_r      <= lidx_nxt;
      ridx_r      <= ridx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    cnt_r      <= cnt_nxt;
    step_r     <= step_nxt;
    lsmp_r     <= lsmp_nxt;
    rsmp_r     <= rsmp_nxt;
    last_r     <= last_nxt;
    lcode_r    <= lcode_nxt;
    rcode_r    <= rcode_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.code_byte = out_byte_r;
  assign out_ch.last_code = out_last_r;

endmodule

`default_nettype wire

FILE: design/ase_checker.sv
`default_nettype none

module ase_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_code_byte,
  input wire logic       out_last_code
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_code_byte) && $stable(out_last_code))
    else $error("result payload changed while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accept");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind adpcm_stereo_encoder ase_checker u_ase_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_code_byte (out_ch.code_byte),
  .out_last_code (out_ch.last_code)
);

`default_nettype wire
